// ===== design/reed_solomon_check_word_encoder_core_defines.svh =====
// assertion macros for the reed-solomon check word encoder
// used by the top level only; no other dependencies
`ifndef REED_SOLOMON_CHECK_WORD_ENCODER_CORE_DEFINES_SVH
`define REED_SOLOMON_CHECK_WORD_ENCODER_CORE_DEFINES_SVH

// same-cycle implication, checked out of reset
`define RSCWE_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define RSCWE_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/rscwe_pkg.sv =====
// shared types, constants and gf(256) arithmetic for the check word encoder
// no dependencies
package rscwe_pkg;

    localparam int MAX_CHECK = 62;
    localparam int CHECK_W   = 6;
    localparam int POLY_W    = 9;
    localparam int INDEX_W   = 2;

    localparam logic [CHECK_W-1:0] RESET_CHECK = 6'd5;
    localparam logic [POLY_W-1:0]  RESET_POLY  = 9'd301;

    // register indexes on the write port
    localparam logic [INDEX_W-1:0] REG_CHECK_COUNT = 2'd0;
    localparam logic [INDEX_W-1:0] REG_FIELD_POLY  = 2'd1;

    typedef struct packed {
        logic [7:0] data_word;
        logic       last_word;
    } data_item_t;

    typedef struct packed {
        logic [7:0] check_word;
        logic       last_check;
    } check_item_t;

    // generator builder status towards the top level
    typedef struct packed {
        logic               busy;
        logic               clear;
        logic [7:0]         root;
        logic [POLY_W-1:0]  poly;
        logic [CHECK_W-1:0] n;
    } gen_stat_t;

    // per-cycle commands broadcast along the cell row
    typedef struct packed {
        logic build_clear;
        logic build_step;
        logic rem_clear;
        logic rem_step;
        logic out_load;
        logic out_shift;
    } cell_ctrl_t;

    function automatic logic [7:0] gf_double(input logic [7:0] v, input logic [POLY_W-1:0] poly);
        logic [8:0] s;
        s = {v, 1'b0};
        if (s[8])
            s = s ^ poly;
        return s[7:0];
    endfunction

    function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b,
                                          input logic [POLY_W-1:0] poly);
        logic [7:0] acc;
        logic [7:0] x;
        acc = 8'h00;
        x   = a;
        for (int i = 0; i < 8; i++)
        begin
            if (b[i])
                acc = acc ^ x;
            x = gf_double(x, poly);
        end
        return acc;
    endfunction

endpackage

// ===== design/reed_solomon_check_word_encoder_core.sv =====
// channel   direction  beat content                 handshake
// data      in         data_word, last_word         data_valid / data_stall
// check     out        check_word, last_check       check_valid / check_stall
// config    in         reg_index, write_data        write_en
//
// one data word per cycle if not stalled; all remainder stages update in parallel
// a last word loads the output row; n check words leave one per unstalled cycle
// data keeps flowing while check words drain; a further last word waits for room
// after reset or a config write the generator is rebuilt while data is stalled
// depends on rscwe_pkg, rscwe_cell, rscwe_gen_ctrl and the defines header
`include "reed_solomon_check_word_encoder_core_defines.svh"

module reed_solomon_check_word_encoder_core (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          data_valid,
    output logic                          data_stall,
    input  rscwe_pkg::data_item_t         data_item,
    output logic                          check_valid,
    input  logic                          check_stall,
    output rscwe_pkg::check_item_t        check_item,
    input  logic                          write_en,
    input  logic [rscwe_pkg::INDEX_W-1:0] reg_index,
    input  logic [rscwe_pkg::POLY_W-1:0]  write_data
);
    import rscwe_pkg::*;

    gen_stat_t          stat;
    cell_ctrl_t         ctrl;
    logic [7:0]         coef_w [MAX_CHECK];
    logic [7:0]         rem_w  [MAX_CHECK];
    logic [7:0]         out_w  [MAX_CHECK];
    logic [7:0]         fb;
    logic [7:0]         mul_b;
    logic               accept;
    logic               out_beat;
    logic               out_free;
    logic [CHECK_W-1:0] out_left_reg, out_left_next;

    rscwe_gen_ctrl u_gen (
        .clk        (clk),
        .rst_n      (rst_n),
        .write_en   (write_en),
        .reg_index  (reg_index),
        .write_data (write_data),
        .stat       (stat)
    );

    assign out_beat   = check_valid && !check_stall;
    assign out_free   = (out_left_reg == '0) || ((out_left_reg == CHECK_W'(1)) && !check_stall);
    assign data_stall = stat.busy || (data_item.last_word && !out_free);
    assign accept     = data_valid && !data_stall;

    assign fb    = rem_w[0] ^ data_item.data_word;
    assign mul_b = stat.busy ? stat.root : fb;

    assign ctrl.build_clear = stat.clear;
    assign ctrl.build_step  = stat.busy;
    assign ctrl.rem_clear   = stat.clear || (accept && data_item.last_word);
    assign ctrl.rem_step    = accept && !data_item.last_word;
    assign ctrl.out_load    = accept && data_item.last_word;
    assign ctrl.out_shift   = out_beat;

    for (genvar j = 0; j < MAX_CHECK; j++)
    begin : g_cell
        logic [7:0] coef_prev;
        logic [7:0] rem_up;
        logic [7:0] out_up;

        if (j == 0)
        begin : g_head
            assign coef_prev = 8'h01;
        end
        else
        begin : g_body
            assign coef_prev = coef_w[j-1];
        end

        // the top stage sees zero from above
        if (j == MAX_CHECK - 1)
        begin : g_top
            assign rem_up = 8'h00;
            assign out_up = 8'h00;
        end
        else
        begin : g_mid
            assign rem_up = rem_w[j+1];
            assign out_up = out_w[j+1];
        end

        rscwe_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .ctrl      (ctrl),
            .mul_b     (mul_b),
            .poly      (stat.poly),
            .coef_prev (coef_prev),
            .rem_up    (rem_up),
            .out_up    (out_up),
            .coef      (coef_w[j]),
            .rem       (rem_w[j]),
            .out_word  (out_w[j])
        );
    end

    always_comb
    begin
        out_left_next = out_left_reg;
        if (ctrl.out_load)
            out_left_next = stat.n;
        else if (out_beat)
            out_left_next = out_left_reg - CHECK_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_left_reg <= '0;
        else
            out_left_reg <= out_left_next;
    end

    assign check_valid           = (out_left_reg != '0);
    assign check_item.check_word = out_w[0];
    assign check_item.last_check = (out_left_reg == CHECK_W'(1));

    `RSCWE_ASSERT_NOW(a_no_data_in_build, clk, rst_n, data_valid && stat.busy, data_stall, "data taken during generator build")
    `RSCWE_ASSERT_NEXT(a_load_count, clk, rst_n, data_valid && !data_stall && data_item.last_word, check_valid && (out_left_reg == $past(stat.n)), "check run length wrong after last word")
    `RSCWE_ASSERT_NEXT(a_build_after_write, clk, rst_n, stat.clear, stat.busy && (stat.root == 8'h02), "generator build not restarted on config write")

endmodule

// ===== design/rscwe_cell.sv =====
// one cell of the row: generator coefficient, remainder stage and output stage
// depends on rscwe_pkg
module rscwe_cell (
    input  logic                         clk,
    input  logic                         rst_n,
    input  rscwe_pkg::cell_ctrl_t        ctrl,
    input  logic [7:0]                   mul_b,
    input  logic [rscwe_pkg::POLY_W-1:0] poly,
    input  logic [7:0]                   coef_prev,
    input  logic [7:0]                   rem_up,
    input  logic [7:0]                   out_up,
    output logic [7:0]                   coef,
    output logic [7:0]                   rem,
    output logic [7:0]                   out_word
);
    import rscwe_pkg::*;

    logic [7:0] coef_reg, coef_next;
    logic [7:0] rem_reg, rem_next;
    logic [7:0] out_reg, out_next;
    logic [7:0] mul_a;
    logic [7:0] prod;
    logic [7:0] rem_calc;

    // one multiplier serves both the generator build and the lfsr
    assign mul_a    = ctrl.build_step ? coef_prev : coef_reg;
    assign prod     = gf_mul(mul_a, mul_b, poly);
    assign rem_calc = rem_up ^ prod;

    always_comb
    begin
        coef_next = coef_reg;
        if (ctrl.build_clear)
            coef_next = 8'h00;
        else if (ctrl.build_step)
            coef_next = coef_reg ^ prod;
    end

    always_comb
    begin
        rem_next = rem_reg;
        if (ctrl.rem_clear)
            rem_next = 8'h00;
        else if (ctrl.rem_step)
            rem_next = rem_calc;
    end

    always_comb
    begin
        out_next = out_reg;
        if (ctrl.out_load)
            out_next = rem_calc;
        else if (ctrl.out_shift)
            out_next = out_up;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coef_reg <= 8'h00;
            rem_reg  <= 8'h00;
        end
        else
        begin
            coef_reg <= coef_next;
            rem_reg  <= rem_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    assign coef     = coef_reg;
    assign rem      = rem_reg;
    assign out_word = out_reg;

endmodule

// ===== design/rscwe_gen_ctrl.sv =====
// configuration registers and generator build sequencer
// depends on rscwe_pkg
module rscwe_gen_ctrl (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          write_en,
    input  logic [rscwe_pkg::INDEX_W-1:0] reg_index,
    input  logic [rscwe_pkg::POLY_W-1:0]  write_data,
    output rscwe_pkg::gen_stat_t          stat
);
    import rscwe_pkg::*;

    localparam logic [CHECK_W-1:0] MAX_N = CHECK_W'(MAX_CHECK);

    logic [CHECK_W-1:0] check_count_reg, check_count_next;
    logic [POLY_W-1:0]  poly_reg, poly_next;
    logic               busy_reg, busy_next;
    logic [CHECK_W-1:0] step_cnt_reg, step_cnt_next;
    logic [7:0]         root_reg, root_next;
    logic [CHECK_W-1:0] n;
    logic               wr_hit;

    always_comb
    begin
        n = check_count_reg;
        if (check_count_reg == '0)
            n = CHECK_W'(1);
        else if (check_count_reg > MAX_N)
            n = MAX_N;
    end

    assign wr_hit = write_en && ((reg_index == REG_CHECK_COUNT) || (reg_index == REG_FIELD_POLY));

    always_comb
    begin
        check_count_next = check_count_reg;
        poly_next        = poly_reg;
        busy_next        = busy_reg;
        step_cnt_next    = step_cnt_reg;
        root_next        = root_reg;
        if (wr_hit)
        begin
            case (reg_index)
                REG_CHECK_COUNT: check_count_next = write_data[CHECK_W-1:0];
                REG_FIELD_POLY:  poly_next        = write_data;
                default:         poly_next        = poly_reg;
            endcase
            busy_next     = 1'b1;
            step_cnt_next = '0;
            root_next     = 8'h02;
        end
        else if (busy_reg)
        begin
            // one root factor folded in per cycle
            root_next     = gf_double(root_reg, poly_reg);
            step_cnt_next = step_cnt_reg + CHECK_W'(1);
            if (step_cnt_reg == n - CHECK_W'(1))
                busy_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            check_count_reg <= RESET_CHECK;
            poly_reg        <= RESET_POLY;
            busy_reg        <= 1'b1;
            step_cnt_reg    <= '0;
            root_reg        <= 8'h02;
        end
        else
        begin
            check_count_reg <= check_count_next;
            poly_reg        <= poly_next;
            busy_reg        <= busy_next;
            step_cnt_reg    <= step_cnt_next;
            root_reg        <= root_next;
        end
    end

    assign stat.busy  = busy_reg;
    assign stat.clear = wr_hit;
    assign stat.root  = root_reg;
    assign stat.poly  = poly_reg;
    assign stat.n     = n;

endmodule
